// ===== rtl/core/rbbt_pkg.sv =====
package rbbt_pkg;

   localparam int DIGIT_BITS     = 8;
   localparam int ACTION_BITS    = 3;
   localparam int WINDOW_BITS    = 7;
   localparam int LIMIT_BITS     = 10;
   localparam int BAND_BITS      = 11;
   localparam int BAND_SQ_BITS   = 2 * BAND_BITS;
   localparam int BAND_SHIFT     = 16;
   localparam int HELD_BITS      = LIMIT_BITS + 1;
   localparam int CASH_BITS      = 48;
   localparam int CASH_EXT_BITS  = CASH_BITS + 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   localparam logic [ACTION_BITS-1:0] ACT_WARMUP       = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_HOLD         = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_BUY          = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_SELL         = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_BUY_BLOCKED  = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_SELL_BLOCKED = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND   = 2'd2;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd20;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 10'd5;
   localparam logic [BAND_BITS-1:0]   BAND_RESET   = 11'd512;

   localparam logic signed [CASH_BITS-1:0] CASH_MAX = {1'b0, {(CASH_BITS-1){1'b1}}};
   localparam logic signed [CASH_BITS-1:0] CASH_MIN = {1'b1, {(CASH_BITS-1){1'b0}}};

   typedef struct packed {
      logic load;
      logic step;
      logic sub;
   } mac_ctrl_type;

   function automatic logic signed [CASH_BITS-1:0] sat_cash(
      input logic signed [CASH_EXT_BITS-1:0] v
   );
      logic signed [CASH_EXT_BITS-1:0] hi;
      logic signed [CASH_EXT_BITS-1:0] lo;
      hi = CASH_EXT_BITS'(CASH_MAX);
      lo = CASH_EXT_BITS'(CASH_MIN);
      if (v > hi) begin
         sat_cash = CASH_MAX;
      end else if (v < lo) begin
         sat_cash = CASH_MIN;
      end else begin
         sat_cash = v[CASH_BITS-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/rbbt_mac.sv =====
module rbbt_mac
   import rbbt_pkg::*;
#(
   parameter int ACC_BITS = 85,
   parameter int MUL_BITS = 31
) (
   input  logic                clock,
   input  mac_ctrl_type        ctrl,
   input  logic [ACC_BITS-1:0] acc_init,
   input  logic [ACC_BITS-1:0] x_init,
   input  logic [MUL_BITS-1:0] y_init,
   output logic [ACC_BITS-1:0] acc,
   output logic [ACC_BITS-1:0] acc_next,
   output logic                last
);

   logic [ACC_BITS-1:0]            acc_ff, acc_in;
   logic [ACC_BITS-1:0]            x_ff, x_in;
   logic [MUL_BITS-1:0]            y_ff, y_in;
   logic                           sub_ff, sub_in;
   logic [ACC_BITS+DIGIT_BITS-1:0] prod;
   logic [ACC_BITS-1:0]            sum;

   // one 8-bit digit of y per cycle while step is high, x moves up a digit each step
   always_comb begin
      prod   = x_ff * y_ff[DIGIT_BITS-1:0];
      sum    = sub_ff ? acc_ff - prod[ACC_BITS-1:0] : acc_ff + prod[ACC_BITS-1:0];
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      sub_in = sub_ff;
      if (ctrl.load) begin
         acc_in = acc_init;
         x_in   = x_init;
         y_in   = y_init;
         sub_in = ctrl.sub;
      end else if (ctrl.step) begin
         acc_in = sum;
         x_in   = x_ff << DIGIT_BITS;
         y_in   = y_ff >> DIGIT_BITS;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      sub_ff <= sub_in;
   end

   assign acc      = acc_ff;
   assign acc_next = sum;
   // stop once the digits still to come are all zero
   assign last     = (y_ff >> DIGIT_BITS) == '0;

endmodule

// ===== rtl/core/rolling_band_breakout_trader.sv =====
// Rolling band breakout trader: one price per item, one result per item. The block is busy
// from the accepted item until its result is loaded into the output register, and takes the
// next item while that result still waits. All products (price squares, N*Q - S^2, the band
// term, the deviation N*P - S, the squared deviation and the marked value) run through one
// multiply-accumulate unit that consumes one 8-bit digit of its narrow operand per cycle and
// stops early when the remaining digits are zero. The price ring is a memory with one read
// and one write per item and needs no clearing after reset; configuration is always ready,
// and a window_length write restarts warm-up while keeping position and cash.
module rolling_band_breakout_trader
   import rbbt_pkg::*;
#(
   parameter int WINDOW_MAX = 64,
   parameter int PRICE_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [PRICE_BITS-1:0]       req_price_ticks,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ACTION_BITS-1:0]      rsp_action,
   output logic signed [HELD_BITS-1:0] rsp_position,
   output logic signed [CASH_BITS-1:0] rsp_cash_balance,
   output logic signed [CASH_BITS-1:0] rsp_marked_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data
);

   localparam int WINDOW_REG_MAX = (1 << WINDOW_BITS) - 1;
   localparam int N_MAX     = (WINDOW_MAX < WINDOW_REG_MAX) ? WINDOW_MAX : WINDOW_REG_MAX;
   localparam int N_BITS    = $clog2(N_MAX + 1);
   localparam int PTR_BITS  = $clog2(WINDOW_MAX);
   localparam int SUM_BITS  = PRICE_BITS + N_BITS;
   localparam int SQ_BITS   = 2 * PRICE_BITS + N_BITS;
   localparam int VAR_BITS  = SQ_BITS + N_BITS;
   localparam int RHS_BITS  = VAR_BITS + BAND_SQ_BITS;
   localparam int ACC_WANT  = RHS_BITS + 1;
   localparam int ACC_BITS  = (ACC_WANT > CASH_EXT_BITS) ? ACC_WANT : CASH_EXT_BITS;
   localparam int MUL_BITS  = (SUM_BITS > BAND_SQ_BITS) ? SUM_BITS : BAND_SQ_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [3:0] OP_QNEW = 4'd0;
   localparam logic [3:0] OP_QOLD = 4'd1;
   localparam logic [3:0] OP_DVN  = 4'd2;
   localparam logic [3:0] OP_DVS  = 4'd3;
   localparam logic [3:0] OP_BSQ  = 4'd4;
   localparam logic [3:0] OP_RHS  = 4'd5;
   localparam logic [3:0] OP_DIFF = 4'd6;
   localparam logic [3:0] OP_LHS  = 4'd7;
   localparam logic [3:0] OP_MARK = 4'd8;

   logic [1:0]                  state_ff, state_in;
   logic [3:0]                  op_ff, op_in;
   logic [WINDOW_BITS-1:0]      window_ff, window_in;
   logic [LIMIT_BITS-1:0]       limit_ff, limit_in;
   logic [BAND_BITS-1:0]        band_ff, band_in;
   logic [PTR_BITS-1:0]         ptr_ff, ptr_in;
   logic [N_BITS-1:0]           fill_ff, fill_in;
   logic [SUM_BITS-1:0]         sum_ff, sum_in;
   logic [SQ_BITS-1:0]          sq_ff, sq_in;
   logic signed [HELD_BITS-1:0] held_ff, held_in;
   logic signed [CASH_BITS-1:0] cash_ff, cash_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [PRICE_BITS-1:0]       price_ff, price_in;
   logic [PRICE_BITS-1:0]       old_ff;
   logic                        warm_ff, warm_in;
   logic [ACTION_BITS-1:0]      action_ff, action_in;
   logic [VAR_BITS-1:0]         var_ff, var_in;
   logic [BAND_SQ_BITS-1:0]     bsq_ff, bsq_in;
   logic [RHS_BITS-1:0]         rhs_ff, rhs_in;
   logic [SUM_BITS-1:0]         dmag_ff, dmag_in;
   logic                        dpos_ff, dpos_in;
   logic                        dneg_ff, dneg_in;
   logic [ACTION_BITS-1:0]      rsp_action_ff, rsp_action_in;
   logic signed [HELD_BITS-1:0] rsp_position_ff, rsp_position_in;
   logic signed [CASH_BITS-1:0] rsp_cash_ff, rsp_cash_in;
   logic signed [CASH_BITS-1:0] rsp_marked_ff, rsp_marked_in;

   logic [PRICE_BITS-1:0]       ring_mem [WINDOW_MAX];

   mac_ctrl_type                mac_ctrl;
   logic [ACC_BITS-1:0]         acc_init, x_init, acc, acc_next;
   logic [MUL_BITS-1:0]         y_init;
   logic                        mac_last;

   logic [N_BITS-1:0]           n_eff;
   logic [PTR_BITS:0]           ptr_inc;
   logic signed [HELD_BITS-1:0] limit_s;
   logic [HELD_BITS-1:0]        held_abs;
   logic [ACC_BITS-1:0]         d_abs;
   logic                        d_neg, d_pos, breakout;
   logic signed [ACC_BITS-1:0]  acc_s, mark_max, mark_min;
   logic signed [CASH_BITS-1:0] mark_sat;
   logic signed [CASH_EXT_BITS-1:0] cash_ext, price_ext;

   rbbt_mac #(
      .ACC_BITS (ACC_BITS),
      .MUL_BITS (MUL_BITS)
   ) u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .acc_init (acc_init),
      .x_init   (x_init),
      .y_init   (y_init),
      .acc      (acc),
      .acc_next (acc_next),
      .last     (mac_last)
   );

   always_comb begin
      if (window_ff == '0) begin
         n_eff = N_BITS'(1);
      end else if (32'(window_ff) > N_MAX) begin
         n_eff = N_BITS'(N_MAX);
      end else begin
         n_eff = N_BITS'(window_ff);
      end
   end

   assign ptr_inc   = {1'b0, ptr_ff} + 1'b1;
   assign limit_s   = {1'b0, limit_ff};
   assign held_abs  = held_ff[HELD_BITS-1] ? HELD_BITS'(-held_ff) : HELD_BITS'(held_ff);
   assign d_neg     = acc_next[ACC_BITS-1];
   assign d_pos     = !acc_next[ACC_BITS-1] && (acc_next != '0);
   assign d_abs     = d_neg ? '0 - acc_next : acc_next;
   // positive remainder means d^2 exceeds floor((N*Q - S^2) * band^2 / 65536)
   assign breakout  = d_pos;
   assign acc_s     = acc;
   assign mark_max  = ACC_BITS'(CASH_MAX);
   assign mark_min  = ACC_BITS'(CASH_MIN);
   assign cash_ext  = CASH_EXT_BITS'(cash_ff);
   assign price_ext = CASH_EXT_BITS'(price_ff);

   always_comb begin
      if (acc_s > mark_max) begin
         mark_sat = CASH_MAX;
      end else if (acc_s < mark_min) begin
         mark_sat = CASH_MIN;
      end else begin
         mark_sat = acc_s[CASH_BITS-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      window_in       = window_ff;
      limit_in        = limit_ff;
      band_in         = band_ff;
      ptr_in          = ptr_ff;
      fill_in         = fill_ff;
      sum_in          = sum_ff;
      sq_in           = sq_ff;
      held_in         = held_ff;
      cash_in         = cash_ff;
      rsp_valid_in    = rsp_valid_ff;
      price_in        = price_ff;
      warm_in         = warm_ff;
      action_in       = action_ff;
      var_in          = var_ff;
      bsq_in          = bsq_ff;
      rhs_in          = rhs_ff;
      dmag_in         = dmag_ff;
      dpos_in         = dpos_ff;
      dneg_in         = dneg_ff;
      rsp_action_in   = rsp_action_ff;
      rsp_position_in = rsp_position_ff;
      rsp_cash_in     = rsp_cash_ff;
      rsp_marked_in   = rsp_marked_ff;
      mac_ctrl        = '0;
      acc_init        = '0;
      x_init          = '0;
      y_init          = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               price_in = req_price_ticks;
               warm_in  = fill_ff < n_eff;
               if (fill_ff < n_eff) begin
                  fill_in   = fill_ff + 1'b1;
                  action_in = ACT_WARMUP;
               end else begin
                  action_in = ACT_HOLD;
               end
               if (ptr_inc == (PTR_BITS+1)'(n_eff)) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = ptr_inc[PTR_BITS-1:0];
               end
               op_in    = OP_QNEW;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mac_ctrl.load = 1'b1;
            state_in      = ST_RUN;
            case (op_ff)
               OP_QNEW: begin
                  acc_init = ACC_BITS'(sq_ff);
                  x_init   = ACC_BITS'(price_ff);
                  y_init   = MUL_BITS'(price_ff);
                  // the displaced price leaves the sum once the window is full
                  sum_in   = sum_ff + SUM_BITS'(price_ff)
                             - (warm_ff ? '0 : SUM_BITS'(old_ff));
               end
               OP_QOLD: begin
                  acc_init     = acc;
                  x_init       = ACC_BITS'(old_ff);
                  y_init       = MUL_BITS'(old_ff);
                  mac_ctrl.sub = 1'b1;
               end
               OP_DVN: begin
                  x_init = ACC_BITS'(sq_ff);
                  y_init = MUL_BITS'(n_eff);
               end
               OP_DVS: begin
                  acc_init     = acc;
                  x_init       = ACC_BITS'(sum_ff);
                  y_init       = MUL_BITS'(sum_ff);
                  mac_ctrl.sub = 1'b1;
               end
               OP_BSQ: begin
                  x_init = ACC_BITS'(band_ff);
                  y_init = MUL_BITS'(band_ff);
               end
               OP_RHS: begin
                  x_init = ACC_BITS'(var_ff);
                  y_init = MUL_BITS'(bsq_ff);
               end
               OP_DIFF: begin
                  acc_init = '0 - ACC_BITS'(sum_ff);
                  x_init   = ACC_BITS'(price_ff);
                  y_init   = MUL_BITS'(n_eff);
               end
               OP_LHS: begin
                  acc_init = '0 - (ACC_BITS'(rhs_ff) >> BAND_SHIFT);
                  x_init   = ACC_BITS'(dmag_ff);
                  y_init   = MUL_BITS'(dmag_ff);
               end
               OP_MARK: begin
                  acc_init     = ACC_BITS'(cash_ff);
                  x_init       = ACC_BITS'(price_ff);
                  y_init       = MUL_BITS'(held_abs);
                  mac_ctrl.sub = held_ff[HELD_BITS-1];
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RUN: begin
            mac_ctrl.step = 1'b1;
            if (mac_last) begin
               state_in = ST_LOAD;
               case (op_ff)
                  OP_QNEW: begin
                     if (warm_ff) begin
                        sq_in = acc_next[SQ_BITS-1:0];
                        op_in = OP_MARK;
                     end else begin
                        op_in = OP_QOLD;
                     end
                  end
                  OP_QOLD: begin
                     sq_in = acc_next[SQ_BITS-1:0];
                     op_in = OP_DVN;
                  end
                  OP_DVN: begin
                     op_in = OP_DVS;
                  end
                  OP_DVS: begin
                     var_in = acc_next[VAR_BITS-1:0];
                     op_in  = OP_BSQ;
                  end
                  OP_BSQ: begin
                     bsq_in = acc_next[BAND_SQ_BITS-1:0];
                     op_in  = OP_RHS;
                  end
                  OP_RHS: begin
                     rhs_in = acc_next[RHS_BITS-1:0];
                     op_in  = OP_DIFF;
                  end
                  OP_DIFF: begin
                     dpos_in = d_pos;
                     dneg_in = d_neg;
                     dmag_in = d_abs[SUM_BITS-1:0];
                     op_in   = OP_LHS;
                  end
                  OP_LHS: begin
                     if (breakout && dpos_ff) begin
                        if (held_ff < limit_s) begin
                           action_in = ACT_BUY;
                           held_in   = held_ff + 1'b1;
                           cash_in   = sat_cash(cash_ext - price_ext);
                        end else begin
                           action_in = ACT_BUY_BLOCKED;
                        end
                     end else if (breakout && dneg_ff) begin
                        if (held_ff > -limit_s) begin
                           action_in = ACT_SELL;
                           held_in   = held_ff - 1'b1;
                           cash_in   = sat_cash(cash_ext + price_ext);
                        end else begin
                           action_in = ACT_SELL_BLOCKED;
                        end
                     end
                     op_in = OP_MARK;
                  end
                  OP_MARK: begin
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_action_in   = action_ff;
               rsp_position_in = held_ff;
               rsp_cash_in     = cash_ff;
               rsp_marked_in   = mark_sat;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW: begin
               window_in = csr_data[WINDOW_BITS-1:0];
               ptr_in    = '0;
               fill_in   = '0;
               sum_in    = '0;
               sq_in     = '0;
            end
            CSR_LIMIT: begin
               limit_in = csr_data[LIMIT_BITS-1:0];
            end
            CSR_BAND: begin
               band_in = csr_data[BAND_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_QNEW;
         window_ff    <= WINDOW_RESET;
         limit_ff     <= LIMIT_RESET;
         band_ff      <= BAND_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         held_ff      <= '0;
         cash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
         band_ff      <= band_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         held_ff      <= held_in;
         cash_ff      <= cash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff        <= price_in;
      warm_ff         <= warm_in;
      action_ff       <= action_in;
      var_ff          <= var_in;
      bsq_ff          <= bsq_in;
      rhs_ff          <= rhs_in;
      dmag_ff         <= dmag_in;
      dpos_ff         <= dpos_in;
      dneg_ff         <= dneg_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_position_ff <= rsp_position_in;
      rsp_cash_ff     <= rsp_cash_in;
      rsp_marked_ff   <= rsp_marked_in;
   end

   // read the displaced price and write the new one in the same edge
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         old_ff           <= ring_mem[ptr_ff];
         ring_mem[ptr_ff] <= req_price_ticks;
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_cash_balance = rsp_cash_ff;
   assign rsp_marked_value = rsp_marked_ff;

endmodule
